[rtl/core/dls_pkg.sv]
// Shared constants and codes for the door lock sequencer.
package dls_pkg;

	// Field widths of the tick and status transactions.
	localparam int ELAPSED_W = 12;
	localparam int MV_W      = 12;
	localparam int CMD_W     = 2;
	localparam int PHASE_W   = 2;
	localparam int ANGLE_W   = 8;
	localparam int PULSE_W   = 15;
	localparam int TIME_W    = 16;
	localparam int COUNT_W   = 4;

	// Configuration bus geometry.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	// Register indexes on the configuration bus.
	localparam logic [REG_IDX_W-1:0] REG_UNLOCK_ANGLE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOCK_ANGLE   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_TIME    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MOTION_LEVEL = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_IDLE_LEVEL   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PIR_INTERVAL = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SLOW_BLINK   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_FAST_BLINK   = 3'd7;

	// Register reset values.
	localparam logic [ANGLE_W-1:0] UNLOCK_ANGLE_RST = 8'd90;
	localparam logic [ANGLE_W-1:0] LOCK_ANGLE_RST   = 8'd0;
	localparam logic [TIME_W-1:0]  HOLD_TIME_RST    = 16'd2000;
	localparam logic [MV_W-1:0]    MOTION_LEVEL_RST = 12'd1500;
	localparam logic [MV_W-1:0]    IDLE_LEVEL_RST   = 12'd500;
	localparam logic [TIME_W-1:0]  PIR_INTERVAL_RST = 16'd100;
	localparam logic [TIME_W-1:0]  SLOW_BLINK_RST   = 16'd500;
	localparam logic [TIME_W-1:0]  FAST_BLINK_RST   = 16'd200;

	// Remote command codes.
	localparam logic [CMD_W-1:0] CMD_NONE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd2;

	// Behavior constants.
	localparam logic [ANGLE_W-1:0] STEP_DEGREES   = 8'd5;
	localparam logic [COUNT_W-1:0] DEBOUNCE_COUNT = 4'd3;
	localparam logic [COUNT_W-1:0] IDLE_CONFIRM   = 4'd5;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX      = 8'd180;
	localparam logic [PULSE_W-1:0] PULSE_MIN_US   = 15'd500;
	localparam logic [PULSE_W-1:0] PWM_PERIOD_US  = 15'd20000;

	// angle * 2000 / 180 is angle * 100 / 9; the divide by 9 is a multiply by
	// ceil(2^16 / 9) = 7282 and a shift, exact for all angles up to 180.
	localparam int PULSE_SHIFT = 16;
	localparam int PULSE_PROD_W = 28;
	localparam logic [PULSE_PROD_W-1:0] PULSE_SCALE = 28'd728200;

endpackage

[rtl/core/dls_tick_if.sv]
// Tick channel: one control tick per transaction.
interface dls_tick_if;
	logic                             valid;
	logic                             ready;
	logic [dls_pkg::ELAPSED_W-1:0]    delta_ms;
	logic                             button_raw;
	logic [dls_pkg::MV_W-1:0]         pir_mv;
	logic                             pir_read_ok;
	logic [dls_pkg::CMD_W-1:0]        remote_cmd;
	logic                             link_up;

	modport source (
		output valid, delta_ms, button_raw, pir_mv, pir_read_ok, remote_cmd, link_up,
		input  ready
	);
	modport sink (
		input  valid, delta_ms, button_raw, pir_mv, pir_read_ok, remote_cmd, link_up,
		output ready
	);
endinterface

[rtl/core/dls_status_if.sv]
// Status channel: one result per tick transaction.
interface dls_status_if;
	logic                             valid;
	logic                             ready;
	logic [dls_pkg::PHASE_W-1:0]      door_phase;
	logic [dls_pkg::ANGLE_W-1:0]      servo_angle;
	logic [dls_pkg::PULSE_W-1:0]      servo_pulse;
	logic                             servo_moving;
	logic                             led_lit;

	modport source (
		output valid, door_phase, servo_angle, servo_pulse, servo_moving, led_lit,
		input  ready
	);
	modport sink (
		input  valid, door_phase, servo_angle, servo_pulse, servo_moving, led_lit,
		output ready
	);
endinterface

[rtl/core/door_lock_sequencer_top.sv]
// Door lock sequencer: debounce, PIR hysteresis, lock sequence, servo and LED.
//
// Each tick transaction passes through an input register and a result register,
// with all per-tick work done in one pass of logic between them; the block
// takes one tick per clock cycle while not stalled, and a tick's result enters
// the result register when the tick moves on. The input register accepts
// a new tick while a finished result still waits, so the block only stalls when
// both registers are full. The configuration registers sit on an APB-style port
// at byte address 4*index and must be written only while no tick is in flight.
module door_lock_sequencer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	dls_tick_if.sink                         tick,
	dls_status_if.source                     status,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dls_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [dls_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [dls_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import dls_pkg::*;

	typedef enum logic [PHASE_W-1:0] {
		PH_LOCKED    = 2'd0,
		PH_UNLOCKING = 2'd1,
		PH_UNLOCKED  = 2'd2,
		PH_LOCKING   = 2'd3
	} phase_t;

	// Configuration registers.
	logic [ANGLE_W-1:0] unlock_angle_q, lock_angle_q;
	logic [TIME_W-1:0]  hold_time_q, pir_interval_q, slow_blink_q, fast_blink_q;
	logic [MV_W-1:0]    motion_level_q, idle_level_q;

	// Input register.
	logic                 valid_s1;
	logic [ELAPSED_W-1:0] elapsed_s1;
	logic                 button_raw_s1;
	logic [MV_W-1:0]      pir_mv_s1;
	logic                 pir_read_ok_s1;
	logic [CMD_W-1:0]     remote_cmd_s1;
	logic                 link_up_s1;

	// Result register.
	logic               valid_s2;
	logic [PHASE_W-1:0] phase_s2;
	logic [ANGLE_W-1:0] angle_s2;
	logic [PULSE_W-1:0] pulse_s2;
	logic               moving_s2;
	logic               led_s2;

	// Controller state.
	phase_t             phase_q;
	logic [CMD_W-1:0]   pending_q;
	logic [ANGLE_W-1:0] angle_now_q, angle_goal_q;
	logic [TIME_W-1:0]  hold_left_q;
	logic               btn_stable_q, btn_last_q;
	logic [COUNT_W-1:0] btn_count_q;
	logic [TIME_W-1:0]  pir_accum_q;
	logic               motion_q;
	logic [COUNT_W-1:0] idle_count_q;
	logic [TIME_W-1:0]  led_accum_q;
	logic               led_q;

	// Next-state values.
	logic                    advance;
	logic                    cfg_write;
	logic [REG_IDX_W-1:0]    cfg_idx;
	logic [CMD_W-1:0]        pending_cmd_in, pending_nx;
	logic [TIME_W:0]         pir_sum;
	logic [TIME_W-1:0]       pir_acc, pir_accum_nx;
	logic                    motion_nx;
	logic [COUNT_W-1:0]      idle_inc, idle_count_nx;
	logic                    btn_stable_nx, btn_last_nx;
	logic [COUNT_W-1:0]      btn_inc, btn_count_nx;
	logic [ANGLE_W-1:0]      open_a, shut_a;
	phase_t                  phase_nx;
	logic [ANGLE_W-1:0]      goal_nx, angle_nx;
	logic [TIME_W-1:0]       hold_nx;
	logic [TIME_W-1:0]       elapsed_ext;
	logic [ANGLE_W:0]        step_up;
	logic [ANGLE_W-1:0]      step_down;
	logic                    moving_nx;
	logic [TIME_W:0]         led_sum;
	logic [TIME_W-1:0]       led_acc, led_accum_nx;
	logic                    led_nx;
	logic [ANGLE_W-1:0]      pulse_angle;
	logic [PULSE_PROD_W-1:0] pulse_prod;
	logic [PULSE_W-1:0]      pulse_raw, pulse_nx;

	// Handshake: the input register moves on when the result register is free or being read.
	assign advance      = valid_s1 && (!valid_s2 || status.ready);
	assign tick.ready   = !valid_s1 || advance;
	assign status.valid = valid_s2;

	assign status.door_phase   = phase_s2;
	assign status.servo_angle  = angle_s2;
	assign status.servo_pulse  = pulse_s2;
	assign status.servo_moving = moving_s2;
	assign status.led_lit      = led_s2;

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_idx   = paddr[APB_ADDR_W-1:2];

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_UNLOCK_ANGLE: prdata = {{(APB_DATA_W-ANGLE_W){1'b0}}, unlock_angle_q};
			REG_LOCK_ANGLE:   prdata = {{(APB_DATA_W-ANGLE_W){1'b0}}, lock_angle_q};
			REG_HOLD_TIME:    prdata = {{(APB_DATA_W-TIME_W){1'b0}}, hold_time_q};
			REG_MOTION_LEVEL: prdata = {{(APB_DATA_W-MV_W){1'b0}}, motion_level_q};
			REG_IDLE_LEVEL:   prdata = {{(APB_DATA_W-MV_W){1'b0}}, idle_level_q};
			REG_PIR_INTERVAL: prdata = {{(APB_DATA_W-TIME_W){1'b0}}, pir_interval_q};
			REG_SLOW_BLINK:   prdata = {{(APB_DATA_W-TIME_W){1'b0}}, slow_blink_q};
			REG_FAST_BLINK:   prdata = {{(APB_DATA_W-TIME_W){1'b0}}, fast_blink_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unlock_angle_q <= UNLOCK_ANGLE_RST;
			lock_angle_q   <= LOCK_ANGLE_RST;
			hold_time_q    <= HOLD_TIME_RST;
			motion_level_q <= MOTION_LEVEL_RST;
			idle_level_q   <= IDLE_LEVEL_RST;
			pir_interval_q <= PIR_INTERVAL_RST;
			slow_blink_q   <= SLOW_BLINK_RST;
			fast_blink_q   <= FAST_BLINK_RST;
		end else if (cfg_write) begin
			case (cfg_idx)
				REG_UNLOCK_ANGLE: unlock_angle_q <= pwdata[ANGLE_W-1:0];
				REG_LOCK_ANGLE:   lock_angle_q   <= pwdata[ANGLE_W-1:0];
				REG_HOLD_TIME:    hold_time_q    <= pwdata[TIME_W-1:0];
				REG_MOTION_LEVEL: motion_level_q <= pwdata[MV_W-1:0];
				REG_IDLE_LEVEL:   idle_level_q   <= pwdata[MV_W-1:0];
				REG_PIR_INTERVAL: pir_interval_q <= pwdata[TIME_W-1:0];
				REG_SLOW_BLINK:   slow_blink_q   <= pwdata[TIME_W-1:0];
				REG_FAST_BLINK:   fast_blink_q   <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign elapsed_ext = {{(TIME_W-ELAPSED_W){1'b0}}, elapsed_s1};

	// Latch the remote command; only lock and unlock replace the pending one.
	assign pending_cmd_in = (remote_cmd_s1 == CMD_LOCK || remote_cmd_s1 == CMD_UNLOCK) ?
		remote_cmd_s1 : pending_q;

	// PIR sampling with a saturating interval accumulator and idle confirmation.
	assign pir_sum  = {1'b0, pir_accum_q} + {1'b0, elapsed_ext};
	assign pir_acc  = pir_sum[TIME_W] ? {TIME_W{1'b1}} : pir_sum[TIME_W-1:0];
	assign idle_inc = idle_count_q + 4'd1;

	always_comb begin
		pir_accum_nx  = pir_acc;
		motion_nx     = motion_q;
		idle_count_nx = idle_count_q;
		if (pir_acc >= pir_interval_q) begin
			pir_accum_nx = '0;
			if (pir_read_ok_s1) begin
				if (pir_mv_s1 >= motion_level_q) begin
					idle_count_nx = '0;
					motion_nx     = 1'b1;
				end else if (pir_mv_s1 <= idle_level_q) begin
					idle_count_nx = idle_inc;
					if (idle_inc >= IDLE_CONFIRM) begin
						motion_nx     = 1'b0;
						idle_count_nx = IDLE_CONFIRM;
					end
				end
			end
		end
	end

	// Button debounce: the level must repeat before it becomes stable.
	assign btn_inc = btn_count_q + 4'd1;

	always_comb begin
		btn_stable_nx = btn_stable_q;
		btn_last_nx   = btn_last_q;
		btn_count_nx  = btn_count_q;
		if (button_raw_s1 == btn_last_q) begin
			if (btn_count_q < DEBOUNCE_COUNT) begin
				btn_count_nx = btn_inc;
				if (btn_inc >= DEBOUNCE_COUNT) begin
					btn_stable_nx = button_raw_s1;
				end
			end
		end else begin
			btn_count_nx = '0;
			btn_last_nx  = button_raw_s1;
		end
	end

	// Lock sequence.
	assign open_a = (unlock_angle_q > ANGLE_MAX) ? ANGLE_MAX : unlock_angle_q;
	assign shut_a = (lock_angle_q > ANGLE_MAX) ? ANGLE_MAX : lock_angle_q;

	always_comb begin
		phase_nx   = phase_q;
		goal_nx    = angle_goal_q;
		hold_nx    = hold_left_q;
		pending_nx = pending_cmd_in;
		case (phase_q)
			PH_LOCKED: begin
				if (pending_cmd_in == CMD_UNLOCK) begin
					goal_nx    = open_a;
					phase_nx   = PH_UNLOCKING;
					pending_nx = CMD_NONE;
				end else if (motion_nx && !btn_stable_nx) begin
					goal_nx  = open_a;
					phase_nx = PH_UNLOCKING;
				end
			end
			PH_UNLOCKING: begin
				if (angle_now_q == open_a) begin
					hold_nx  = hold_time_q;
					phase_nx = PH_UNLOCKED;
				end
			end
			PH_UNLOCKED: begin
				if (pending_cmd_in == CMD_LOCK) begin
					goal_nx    = shut_a;
					phase_nx   = PH_LOCKING;
					pending_nx = CMD_NONE;
				end else if (hold_left_q <= elapsed_ext) begin
					goal_nx  = shut_a;
					phase_nx = PH_LOCKING;
				end else begin
					hold_nx = hold_left_q - elapsed_ext;
				end
			end
			default: begin
				if (angle_now_q == shut_a) begin
					phase_nx = PH_LOCKED;
				end
			end
		endcase
	end

	// Servo slew toward the goal without overshoot.
	assign step_up   = {1'b0, angle_now_q} + {1'b0, STEP_DEGREES};
	assign step_down = (angle_now_q < STEP_DEGREES) ? '0 : angle_now_q - STEP_DEGREES;
	assign moving_nx = (angle_now_q != goal_nx);

	always_comb begin
		angle_nx = angle_now_q;
		if (angle_now_q < goal_nx) begin
			angle_nx = (step_up > {1'b0, goal_nx}) ? goal_nx : step_up[ANGLE_W-1:0];
		end else if (angle_now_q > goal_nx) begin
			angle_nx = (step_down < goal_nx) ? goal_nx : step_down;
		end
	end

	// LED: fast blink while moving, slow blink with the link down, else steady.
	assign led_sum = {1'b0, led_accum_q} + {1'b0, elapsed_ext};
	assign led_acc = led_sum[TIME_W] ? {TIME_W{1'b1}} : led_sum[TIME_W-1:0];

	always_comb begin
		led_accum_nx = led_acc;
		led_nx       = led_q;
		if (phase_nx == PH_UNLOCKING || phase_nx == PH_LOCKING) begin
			if (led_acc >= fast_blink_q) begin
				led_accum_nx = '0;
				led_nx       = !led_q;
			end
		end else if (link_up_s1) begin
			led_nx = (phase_nx == PH_UNLOCKED);
		end else if (led_acc >= slow_blink_q) begin
			led_accum_nx = '0;
			led_nx       = !led_q;
		end
	end

	// Servo pulse width from the new angle, clamped to the PWM period.
	assign pulse_angle = (angle_nx > ANGLE_MAX) ? ANGLE_MAX : angle_nx;
	assign pulse_prod  = {{(PULSE_PROD_W-ANGLE_W){1'b0}}, pulse_angle} * PULSE_SCALE;
	assign pulse_raw   = PULSE_MIN_US +
		{{(PULSE_W-(PULSE_PROD_W-PULSE_SHIFT)){1'b0}}, pulse_prod[PULSE_PROD_W-1:PULSE_SHIFT]};
	assign pulse_nx    = (pulse_raw > PWM_PERIOD_US) ? PWM_PERIOD_US : pulse_raw;

	// Input register, result register and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			phase_q      <= PH_LOCKED;
			pending_q    <= CMD_NONE;
			angle_now_q  <= '0;
			angle_goal_q <= '0;
			hold_left_q  <= '0;
			btn_stable_q <= 1'b1;
			btn_last_q   <= 1'b1;
			btn_count_q  <= '0;
			pir_accum_q  <= '0;
			motion_q     <= 1'b0;
			idle_count_q <= '0;
			led_accum_q  <= '0;
			led_q        <= 1'b0;
		end else begin
			if (tick.ready) begin
				valid_s1 <= tick.valid;
			end
			if (tick.valid && tick.ready) begin
				elapsed_s1     <= tick.delta_ms;
				button_raw_s1  <= tick.button_raw;
				pir_mv_s1      <= tick.pir_mv;
				pir_read_ok_s1 <= tick.pir_read_ok;
				remote_cmd_s1  <= tick.remote_cmd;
				link_up_s1     <= tick.link_up;
			end
			if (advance) begin
				valid_s2     <= 1'b1;
				phase_s2     <= phase_nx;
				angle_s2     <= angle_nx;
				pulse_s2     <= pulse_nx;
				moving_s2    <= moving_nx;
				led_s2       <= led_nx;
				phase_q      <= phase_nx;
				pending_q    <= pending_nx;
				angle_now_q  <= angle_nx;
				angle_goal_q <= goal_nx;
				hold_left_q  <= hold_nx;
				btn_stable_q <= btn_stable_nx;
				btn_last_q   <= btn_last_nx;
				btn_count_q  <= btn_count_nx;
				pir_accum_q  <= pir_accum_nx;
				motion_q     <= motion_nx;
				idle_count_q <= idle_count_nx;
				led_accum_q  <= led_accum_nx;
				led_q        <= led_nx;
			end else if (status.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

endmodule

[sim/door_lock_sequencer_top_test.sv]
// Self-checking testbench for the door lock sequencer: random ticks, register setups, status checks.
module door_lock_sequencer_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dls_pkg::*;

	localparam int PULSE_SPAN_US = 2000;
	localparam int CYCLE_LIMIT   = 200000;

	// Remote command code that carries no meaning.
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	typedef enum logic [PHASE_W-1:0] {
		PH_LOCKED    = 2'd0,
		PH_UNLOCKING = 2'd1,
		PH_UNLOCKED  = 2'd2,
		PH_LOCKING   = 2'd3
	} door_phase_e;

	typedef struct packed {
		logic [ELAPSED_W-1:0] delta_ms;
		logic                 button_raw;
		logic [MV_W-1:0]      pir_mv;
		logic                 pir_read_ok;
		logic [CMD_W-1:0]     remote_cmd;
		logic                 link_up;
	} tick_t;

	typedef struct packed {
		logic [PHASE_W-1:0] door_phase;
		logic [ANGLE_W-1:0] servo_angle;
		logic [PULSE_W-1:0] servo_pulse;
		logic               servo_moving;
		logic               led_lit;
	} status_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	dls_tick_if   tick_bus ();
	dls_status_if status_bus ();

	door_lock_sequencer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_bus),
		.status  (status_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Ticks waiting to be driven and the status each accepted tick should produce.
	tick_t   pending_ticks [$];
	status_t expected_status [$];
	tick_t   on_bus;
	int      fail_count;
	int      cycle_count;
	int      sender_idle_pct;
	int      receiver_idle_pct;

	// Shadow copy of the configuration registers, masked to their widths.
	logic [TIME_W-1:0] reg_shadow [1<<REG_IDX_W];

	// Predicted state of the door controller.
	door_phase_e        door_now;
	logic [CMD_W-1:0]   cmd_pending;
	logic [ANGLE_W-1:0] angle_now;
	logic [ANGLE_W-1:0] angle_goal;
	logic [TIME_W-1:0]  hold_left;
	logic               btn_stable;
	logic               btn_last;
	logic [COUNT_W-1:0] btn_count;
	logic [TIME_W-1:0]  pir_accum;
	logic               motion_seen;
	logic [COUNT_W-1:0] idle_count;
	logic [TIME_W-1:0]  led_accum;
	logic               led_on;

	always #5 clk = ~clk;

	function automatic logic [TIME_W-1:0] sat_add_ms(input logic [TIME_W-1:0] acc,
			input logic [ELAPSED_W-1:0] add);
		logic [TIME_W:0] sum;
		sum = {1'b0, acc} + add;
		return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
	endfunction

	// Advance the predicted controller by one tick and return the status it reports.
	function automatic status_t predict_status(input tick_t t);
		status_t            r;
		logic [ANGLE_W-1:0] open_deg;
		logic [ANGLE_W-1:0] shut_deg;
		logic [TIME_W-1:0]  blink_ms;
		logic               pressed;
		logic               moved;
		int                 step_to;
		int                 pulse_width;

		// A lock or unlock command replaces whatever was pending.
		if (t.remote_cmd == CMD_LOCK || t.remote_cmd == CMD_UNLOCK) begin
			cmd_pending = t.remote_cmd;
		end

		// PIR sampling; the motion test wins over the idle test.
		pir_accum = sat_add_ms(pir_accum, t.delta_ms);
		if (pir_accum >= reg_shadow[REG_PIR_INTERVAL]) begin
			pir_accum = '0;
			if (t.pir_read_ok) begin
				if (t.pir_mv >= reg_shadow[REG_MOTION_LEVEL]) begin
					idle_count  = '0;
					motion_seen = 1'b1;
				end else if (t.pir_mv <= reg_shadow[REG_IDLE_LEVEL]) begin
					idle_count = idle_count + 1'b1;
					if (idle_count >= IDLE_CONFIRM) begin
						motion_seen = 1'b0;
						idle_count  = IDLE_CONFIRM;
					end
				end
			end
		end

		// Button debounce.
		if (t.button_raw == btn_last) begin
			if (btn_count < DEBOUNCE_COUNT) begin
				btn_count = btn_count + 1'b1;
				if (btn_count >= DEBOUNCE_COUNT) begin
					btn_stable = t.button_raw;
				end
			end
		end else begin
			btn_count = '0;
			btn_last  = t.button_raw;
		end
		pressed = !btn_stable;

		// Lock sequence; angle registers above the servo range act as the maximum.
		open_deg = (reg_shadow[REG_UNLOCK_ANGLE] > ANGLE_MAX) ? ANGLE_MAX :
			reg_shadow[REG_UNLOCK_ANGLE][ANGLE_W-1:0];
		shut_deg = (reg_shadow[REG_LOCK_ANGLE] > ANGLE_MAX) ? ANGLE_MAX :
			reg_shadow[REG_LOCK_ANGLE][ANGLE_W-1:0];
		case (door_now)
			PH_LOCKED: begin
				if (cmd_pending == CMD_UNLOCK) begin
					angle_goal  = open_deg;
					door_now    = PH_UNLOCKING;
					cmd_pending = CMD_NONE;
				end else if (motion_seen && pressed) begin
					angle_goal = open_deg;
					door_now   = PH_UNLOCKING;
				end
			end
			PH_UNLOCKING: begin
				if (angle_now == open_deg) begin
					hold_left = reg_shadow[REG_HOLD_TIME];
					door_now  = PH_UNLOCKED;
				end
			end
			PH_UNLOCKED: begin
				if (cmd_pending == CMD_LOCK) begin
					angle_goal  = shut_deg;
					door_now    = PH_LOCKING;
					cmd_pending = CMD_NONE;
				end else if (hold_left <= t.delta_ms) begin
					angle_goal = shut_deg;
					door_now   = PH_LOCKING;
				end else begin
					hold_left = hold_left - t.delta_ms;
				end
			end
			default: begin
				if (angle_now == shut_deg) begin
					door_now = PH_LOCKED;
				end
			end
		endcase

		// Servo slews toward the goal without overshooting it.
		moved   = (angle_now != angle_goal);
		step_to = int'(angle_now);
		if (angle_now < angle_goal) begin
			step_to = int'(angle_now) + int'(STEP_DEGREES);
			if (step_to > int'(angle_goal)) begin
				step_to = int'(angle_goal);
			end
		end else if (angle_now > angle_goal) begin
			step_to = (angle_now < STEP_DEGREES) ? 0 : int'(angle_now) - int'(STEP_DEGREES);
			if (step_to < int'(angle_goal)) begin
				step_to = int'(angle_goal);
			end
		end
		angle_now = ANGLE_W'(step_to);

		// LED: fast blink while moving, slow blink with the link down, else steady.
		led_accum = sat_add_ms(led_accum, t.delta_ms);
		if (door_now == PH_UNLOCKING || door_now == PH_LOCKING || !t.link_up) begin
			blink_ms = (door_now == PH_UNLOCKING || door_now == PH_LOCKING) ?
				reg_shadow[REG_FAST_BLINK] : reg_shadow[REG_SLOW_BLINK];
			if (led_accum >= blink_ms) begin
				led_accum = '0;
				led_on    = ~led_on;
			end
		end else begin
			led_on = (door_now == PH_UNLOCKED);
		end

		pulse_width = int'(PULSE_MIN_US) + int'(angle_now) * PULSE_SPAN_US / int'(ANGLE_MAX);
		if (pulse_width > int'(PWM_PERIOD_US)) begin
			pulse_width = int'(PWM_PERIOD_US);
		end

		r.door_phase   = door_now;
		r.servo_angle  = angle_now;
		r.servo_pulse  = PULSE_W'(pulse_width);
		r.servo_moving = moved;
		r.led_lit      = led_on;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("[%0t] status mismatch: %s", $time, msg);
	endtask

	// Tick driver: predicts each accepted transaction and offers the next one.
	always @(posedge clk) begin
		tick_t nxt;
		if (!arst_n) begin
			tick_bus.valid <= 1'b0;
		end else begin
			if (tick_bus.valid && tick_bus.ready) begin
				expected_status.push_back(predict_status(on_bus));
			end
			if (!tick_bus.valid || tick_bus.ready) begin
				if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					nxt    = pending_ticks.pop_front();
					on_bus = nxt;
					tick_bus.valid       <= 1'b1;
					tick_bus.delta_ms    <= nxt.delta_ms;
					tick_bus.button_raw  <= nxt.button_raw;
					tick_bus.pir_mv      <= nxt.pir_mv;
					tick_bus.pir_read_ok <= nxt.pir_read_ok;
					tick_bus.remote_cmd  <= nxt.remote_cmd;
					tick_bus.link_up     <= nxt.link_up;
				end else begin
					tick_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Status monitor: compares each accepted transaction with the oldest prediction.
	always @(posedge clk) begin
		status_t got;
		status_t want;
		if (!arst_n) begin
			status_bus.ready <= 1'b0;
		end else begin
			if (status_bus.valid && status_bus.ready) begin
				got.door_phase   = status_bus.door_phase;
				got.servo_angle  = status_bus.servo_angle;
				got.servo_pulse  = status_bus.servo_pulse;
				got.servo_moving = status_bus.servo_moving;
				got.led_lit      = status_bus.led_lit;
				if (expected_status.size() == 0) begin
					report_mismatch("status transaction with no tick outstanding");
				end else begin
					want = expected_status.pop_front();
					if (got.door_phase !== want.door_phase)
						report_mismatch($sformatf("door_phase got %0d expected %0d",
							got.door_phase, want.door_phase));
					if (got.servo_angle !== want.servo_angle)
						report_mismatch($sformatf("servo_angle got %0d expected %0d",
							got.servo_angle, want.servo_angle));
					if (got.servo_pulse !== want.servo_pulse)
						report_mismatch($sformatf("servo_pulse got %0d expected %0d",
							got.servo_pulse, want.servo_pulse));
					if (got.servo_moving !== want.servo_moving)
						report_mismatch($sformatf("servo_moving got %0d expected %0d",
							got.servo_moving, want.servo_moving));
					if (got.led_lit !== want.led_lit)
						report_mismatch($sformatf("led_lit got %0d expected %0d",
							got.led_lit, want.led_lit));
				end
			end
			status_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("door_lock_sequencer_top verification failed");
			$finish;
		end
	end

	// APB write with a setup phase and an access phase; the shadow keeps only the register's width.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] value);
		logic [15:0] junk;
		junk = 16'($urandom_range(65535));
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {junk, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_UNLOCK_ANGLE, REG_LOCK_ANGLE: reg_shadow[idx] = {8'h00, value[ANGLE_W-1:0]};
			REG_MOTION_LEVEL, REG_IDLE_LEVEL: reg_shadow[idx] = {4'h0, value[MV_W-1:0]};
			default: reg_shadow[idx] = value;
		endcase
	endtask

	task automatic program_regs(input logic [15:0] unlock_deg, input logic [15:0] lock_deg,
			input logic [15:0] hold_ms, input logic [15:0] motion_mv,
			input logic [15:0] idle_mv, input logic [15:0] interval_ms,
			input logic [15:0] slow_ms, input logic [15:0] fast_ms);
		write_reg(REG_UNLOCK_ANGLE, unlock_deg);
		write_reg(REG_LOCK_ANGLE, lock_deg);
		write_reg(REG_HOLD_TIME, hold_ms);
		write_reg(REG_MOTION_LEVEL, motion_mv);
		write_reg(REG_IDLE_LEVEL, idle_mv);
		write_reg(REG_PIR_INTERVAL, interval_ms);
		write_reg(REG_SLOW_BLINK, slow_ms);
		write_reg(REG_FAST_BLINK, fast_ms);
	endtask

	// Hold off until every tick is out and every status is back, plus a small margin.
	task automatic wait_idle();
		while (pending_ticks.size() != 0 || tick_bus.valid || expected_status.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Queue bursts of ticks: visitors, quiet stretches, remote commands and noise.
	task automatic queue_traffic(input int count);
		tick_t t;
		int kind;
		int len;
		int k;
		int r;
		logic btn_level;
		logic link_level;
		int mv_lo;
		int mv_hi;
		while (count > 0) begin
			kind       = $urandom_range(99);
			len        = $urandom_range(25, 5);
			btn_level  = 1'($urandom_range(1));
			link_level = ($urandom_range(9) < 7);
			mv_lo      = 0;
			mv_hi      = 4095;
			if (kind < 40) begin
				// Someone at the door: motion and a held button.
				btn_level = 1'b0;
				mv_lo     = int'(reg_shadow[REG_MOTION_LEVEL]);
			end else if (kind < 65) begin
				// Nobody around: released button and idle PIR samples.
				btn_level = 1'b1;
				mv_hi     = int'(reg_shadow[REG_IDLE_LEVEL]);
			end
			for (k = 0; k < len && count > 0; k++) begin
				r = $urandom_range(99);
				if (r < 70) t.delta_ms = ELAPSED_W'($urandom_range(150));
				else if (r < 95) t.delta_ms = ELAPSED_W'($urandom_range(1000));
				else t.delta_ms = ELAPSED_W'($urandom_range(4095));
				t.pir_mv      = MV_W'($urandom_range(mv_hi, mv_lo));
				t.pir_read_ok = ($urandom_range(9) != 0);
				t.remote_cmd  = CMD_NONE;
				if (kind >= 85) begin
					t.button_raw = 1'($urandom_range(1));
					t.link_up    = 1'($urandom_range(1));
					t.remote_cmd = CMD_W'($urandom_range(3));
				end else begin
					t.button_raw = ($urandom_range(9) == 0) ? !btn_level : btn_level;
					t.link_up    = link_level;
					if (kind >= 65 && $urandom_range(4) == 0)
						t.remote_cmd = $urandom_range(1) ? CMD_LOCK : CMD_UNLOCK;
					else if ($urandom_range(32) == 0)
						t.remote_cmd = CMD_W'($urandom_range(3));
				end
				pending_ticks.push_back(t);
				count--;
			end
		end
	endtask

	// Stimulus sequence.
	initial begin
		int k;
		int made;
		int n;
		clk                  = 1'b0;
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		tick_bus.valid       = 1'b0;
		tick_bus.delta_ms    = '0;
		tick_bus.button_raw  = 1'b1;
		tick_bus.pir_mv      = '0;
		tick_bus.pir_read_ok = 1'b0;
		tick_bus.remote_cmd  = CMD_NONE;
		tick_bus.link_up     = 1'b1;
		status_bus.ready     = 1'b0;
		fail_count           = 0;
		cycle_count          = 0;
		sender_idle_pct      = 7;
		receiver_idle_pct    = 7;

		reg_shadow[REG_UNLOCK_ANGLE] = TIME_W'(UNLOCK_ANGLE_RST);
		reg_shadow[REG_LOCK_ANGLE]   = TIME_W'(LOCK_ANGLE_RST);
		reg_shadow[REG_HOLD_TIME]    = HOLD_TIME_RST;
		reg_shadow[REG_MOTION_LEVEL] = TIME_W'(MOTION_LEVEL_RST);
		reg_shadow[REG_IDLE_LEVEL]   = TIME_W'(IDLE_LEVEL_RST);
		reg_shadow[REG_PIR_INTERVAL] = PIR_INTERVAL_RST;
		reg_shadow[REG_SLOW_BLINK]   = SLOW_BLINK_RST;
		reg_shadow[REG_FAST_BLINK]   = FAST_BLINK_RST;

		door_now    = PH_LOCKED;
		cmd_pending = CMD_NONE;
		angle_now   = '0;
		angle_goal  = '0;
		hold_left   = '0;
		btn_stable  = 1'b1;
		btn_last    = 1'b1;
		btn_count   = '0;
		pir_accum   = '0;
		motion_seen = 1'b0;
		idle_count  = '0;
		led_accum   = '0;
		led_on      = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening with reset settings: zero and full-scale fields, the unused
		// command code, a lock command while locked that stays pending, debounce,
		// motion with a pressed button, the full open move and the pending lock.
		pending_ticks.push_back('{12'd0, 1'b1, 12'd0, 1'b0, CMD_NONE, 1'b1});
		pending_ticks.push_back('{12'd4095, 1'b1, 12'd4095, 1'b1, CMD_SPARE, 1'b0});
		pending_ticks.push_back('{12'd1, 1'b0, 12'd3300, 1'b1, CMD_LOCK, 1'b0});
		pending_ticks.push_back('{12'd1, 1'b0, 12'd0, 1'b1, CMD_NONE, 1'b1});
		pending_ticks.push_back('{12'd1, 1'b0, 12'd0, 1'b0, CMD_NONE, 1'b1});
		pending_ticks.push_back('{12'd1, 1'b0, 12'd0, 1'b1, CMD_NONE, 1'b1});
		for (k = 0; k < 19; k++)
			pending_ticks.push_back('{12'd50, 1'b1, 12'd0, 1'b1, CMD_NONE, 1'(k % 2)});
		wait_idle();

		// Random traffic under a series of register settings.
		for (int setting = 0; setting < 9; setting++) begin
			case (setting)
				// Open angle beyond range, zero hold, motion level below idle level,
				// sampling on every tick and the shortest nonzero blink periods.
				0: program_regs(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd1);
				// Largest hold, motion level, interval and blink values: the accumulators have to saturate.
				1: program_regs(16'd0, 16'd180, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF,
					16'hFFFF, 16'hFFFF);
				2: program_regs(16'd120, 16'd10, 16'd300, 16'd2000, 16'd400, 16'd20,
					16'd150, 16'd60);
				8: program_regs(16'(UNLOCK_ANGLE_RST), 16'(LOCK_ANGLE_RST), HOLD_TIME_RST,
					16'(MOTION_LEVEL_RST), 16'(IDLE_LEVEL_RST), PIR_INTERVAL_RST,
					SLOW_BLINK_RST, FAST_BLINK_RST);
				default: program_regs(16'($urandom_range(255)), 16'($urandom_range(255)),
					16'($urandom_range(2500)), 16'($urandom_range(3300, 800)),
					16'($urandom_range(1200)), 16'($urandom_range(300)),
					16'($urandom_range(800)), 16'($urandom_range(400)));
			endcase
			// One setting runs with no idle cycles on either side.
			sender_idle_pct   = (setting == 2) ? 0 : 7;
			receiver_idle_pct = (setting == 2) ? 0 : 7;
			made = 0;
			while (made < 115) begin
				n = $urandom_range(110, 40);
				queue_traffic(n);
				made += n;
				wait_idle();
			end
		end

		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("door_lock_sequencer_top verification clean");
		end else begin
			$display("door_lock_sequencer_top verification failed");
		end
		$finish;
	end

endmodule
